/* src/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and constants for the button debouncer
// Holds the item and result payloads, the register map, the configuration
// bundle and the lane control and status structs.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Number of buttons; it sets the widths of the per-button payload fields.
  localparam int BUTTON_COUNT = 3;

  // Register map: word index taken from paddr[3:2].
  localparam int          ADDR_WIDTH             = 4;
  localparam logic [1:0]  REG_PRESSED_LEVEL      = 2'd0;
  localparam logic [1:0]  REG_LONG_PRESS_TICKS   = 2'd1;
  localparam logic [1:0]  REG_REPEAT_TICKS       = 2'd2;
  localparam logic [1:0]  REG_IDLE_TIMEOUT_TICKS = 2'd3;

  // Register reset values.
  localparam logic        PRESSED_LEVEL_RESET      = 1'b0;
  localparam logic [15:0] LONG_PRESS_TICKS_RESET   = 16'd300;
  localparam logic [15:0] REPEAT_TICKS_RESET       = 16'd100;
  localparam logic [15:0] IDLE_TIMEOUT_TICKS_RESET = 16'd1000;

  // Sample history resets to the released level under the reset pressed level.
  localparam logic [3:0]  HISTORY_RESET = {4{~PRESSED_LEVEL_RESET}};
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // Item action codes.
  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_ACK  = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [BUTTON_COUNT-1:0] raw_levels;
    logic [BUTTON_COUNT-1:0] clear_press_mask;
    logic [BUTTON_COUNT-1:0] clear_long_mask;
  } item_t;

  typedef struct packed {
    logic [BUTTON_COUNT-1:0] press_flags;
    logic [BUTTON_COUNT-1:0] long_flags;
    logic                    any_raw_pressed;
    logic                    idle_expired;
  } result_t;

  typedef struct packed {
    logic        pressed_level;
    logic [15:0] long_press_ticks;
    logic [15:0] repeat_ticks;
    logic [15:0] idle_timeout_ticks;
  } cfg_t;

  // Per-item control broadcast to every lane and the merging stage.
  typedef struct packed {
    logic tick;
    logic ack;
  } lane_ctrl_t;

  // What one lane reports for the item now being transferred.
  typedef struct packed {
    logic press_flag;
    logic long_flag;
    logic newest_pressed;
    logic stable_press;
  } lane_status_t;

endpackage

/* src/bdlp_regs.sv */
// ----------------------------------------------------------------------------
// bdlp_regs: configuration registers
// APB-style register file for the pressed level, long-press threshold,
// repeat period and idle timeout. Writes complete in the access cycle.
// ----------------------------------------------------------------------------
module bdlp_regs
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_level      <= PRESSED_LEVEL_RESET;
      cfg.long_press_ticks   <= LONG_PRESS_TICKS_RESET;
      cfg.repeat_ticks       <= REPEAT_TICKS_RESET;
      cfg.idle_timeout_ticks <= IDLE_TIMEOUT_TICKS_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_PRESSED_LEVEL:      cfg.pressed_level      <= pwdata[0];
        REG_LONG_PRESS_TICKS:   cfg.long_press_ticks   <= pwdata[15:0];
        REG_REPEAT_TICKS:       cfg.repeat_ticks       <= pwdata[15:0];
        REG_IDLE_TIMEOUT_TICKS: cfg.idle_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_index)
      REG_PRESSED_LEVEL:      prdata = {31'd0, cfg.pressed_level};
      REG_LONG_PRESS_TICKS:   prdata = {16'd0, cfg.long_press_ticks};
      REG_REPEAT_TICKS:       prdata = {16'd0, cfg.repeat_ticks};
      REG_IDLE_TIMEOUT_TICKS: prdata = {16'd0, cfg.idle_timeout_ticks};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

/* src/bdlp_lane.sv */
// ----------------------------------------------------------------------------
// bdlp_lane: debounce and long-press core for one button
// Keeps the sample history, hold counter, repeat countdown and the sticky
// press and long-press flags of a single button.
// ----------------------------------------------------------------------------
module bdlp_lane
  import bdlp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  lane_ctrl_t   ctrl,
  input  cfg_t         cfg,
  input  logic         raw,
  input  logic         clr_press,
  input  logic         clr_long,
  output lane_status_t status
);

  logic [3:0]  history;
  logic [15:0] hold_count;
  logic [15:0] repeat_count;
  logic        press_pending;
  logic        long_pending;

  logic [3:0]  history_next;
  logic [15:0] hold_count_next;
  logic [15:0] repeat_count_next;
  logic        press_pending_next;
  logic        long_pending_next;
  logic        stable_press;

  logic s1, s2, stable_old, agree;
  logic [15:0] hold_inc;

  assign s1         = history[0];
  assign s2         = history[1];
  assign stable_old = history[3];
  assign agree      = (raw == s1) && (s1 == s2);
  assign hold_inc   = (hold_count == COUNT_MAX) ? hold_count : 16'(hold_count + 16'd1);

  // Effect of a sample tick on this button.
  always_comb begin
    hold_count_next    = hold_count;
    repeat_count_next  = repeat_count;
    press_pending_next = press_pending;
    long_pending_next  = long_pending;
    stable_press       = 1'b0;
    history_next       = {stable_old, s2, s1, raw};
    if (agree) begin
      if (s2 != stable_old) begin
        // A new stable level; a stable press raises the press flag.
        history_next[3] = s2;
        if (s2 == cfg.pressed_level) begin
          press_pending_next = 1'b1;
          hold_count_next    = 16'd0;
          repeat_count_next  = cfg.repeat_ticks;
          stable_press       = 1'b1;
        end
      end else if (s2 == cfg.pressed_level) begin
        // Held press: count the hold, then run the repeat countdown.
        hold_count_next = hold_inc;
        if (hold_inc >= cfg.long_press_ticks) begin
          if (repeat_count == 16'd0) begin
            long_pending_next = 1'b1;
            repeat_count_next = cfg.repeat_ticks;
          end else begin
            repeat_count_next = 16'(repeat_count - 16'd1);
          end
        end
        stable_press = 1'b1;
      end
    end else begin
      // Bouncing samples restart the hold.
      hold_count_next   = 16'd0;
      repeat_count_next = cfg.repeat_ticks;
    end
  end

  // State update on the transfer of an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      history       <= HISTORY_RESET;
      hold_count    <= 16'd0;
      repeat_count  <= 16'd0;
      press_pending <= 1'b0;
      long_pending  <= 1'b0;
    end else if (ctrl.tick) begin
      history       <= history_next;
      hold_count    <= hold_count_next;
      repeat_count  <= repeat_count_next;
      press_pending <= press_pending_next;
      long_pending  <= long_pending_next;
    end else if (ctrl.ack) begin
      if (clr_press) begin
        press_pending <= 1'b0;
      end
      if (clr_long) begin
        long_pending <= 1'b0;
      end
    end
  end

  // A tick reports flags after its update; an acknowledge reports them before clearing.
  always_comb begin
    status.press_flag     = ctrl.tick ? press_pending_next : press_pending;
    status.long_flag      = ctrl.tick ? long_pending_next : long_pending;
    status.newest_pressed = (ctrl.tick ? raw : s1) == cfg.pressed_level;
    status.stable_press   = ctrl.tick && stable_press;
  end

endmodule

/* src/bdlp_merge.sv */
// ----------------------------------------------------------------------------
// bdlp_merge: merging stage and result buffer
// Combines the lane reports, runs the shared idle countdown and holds the
// results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module bdlp_merge
  import bdlp_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  lane_ctrl_t                       ctrl,
  input  cfg_t                             cfg,
  input  lane_status_t [BUTTON_COUNT-1:0]  status,
  output logic                             buf_full,
  output logic                             result_valid,
  input  logic                             result_stall,
  output result_t                          result
);

  logic [15:0] idle_count;
  logic [15:0] idle_count_next;
  logic        any_stable_press;
  result_t     merged;
  result_t     skid;
  logic        skid_valid;
  logic        item_fire;
  logic        result_fire;

  assign item_fire   = ctrl.tick || ctrl.ack;
  assign result_fire = result_valid && !result_stall;
  assign buf_full    = skid_valid;

  // Gather the lane reports.
  always_comb begin
    any_stable_press       = 1'b0;
    merged.any_raw_pressed = 1'b0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      merged.press_flags[i]  = status[i].press_flag;
      merged.long_flags[i]   = status[i].long_flag;
      merged.any_raw_pressed = merged.any_raw_pressed | status[i].newest_pressed;
      any_stable_press       = any_stable_press | status[i].stable_press;
    end
    merged.idle_expired = (idle_count_next == 16'd0);
  end

  // Idle countdown: reloaded by a stable press, otherwise runs down to zero.
  always_comb begin
    idle_count_next = idle_count;
    if (ctrl.tick) begin
      if (any_stable_press) begin
        idle_count_next = cfg.idle_timeout_ticks;
      end else if (idle_count != 16'd0) begin
        idle_count_next = 16'(idle_count - 16'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= IDLE_TIMEOUT_TICKS_RESET;
    end else if (item_fire) begin
      idle_count <= idle_count_next;
    end
  end

  // Two-entry output buffer: the skid entry takes a result while the main one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (item_fire) begin
      if (result_valid && !result_fire) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (result_fire) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_fire) begin
        result <= skid;
      end
    end else if (item_fire) begin
      if (result_valid && !result_fire) begin
        skid <= merged;
      end else begin
        result <= merged;
      end
    end
  end

endmodule

/* src/button_debounce_long_press.sv */
// Results are registered in the main output entry, or in the skid entry while
// it is stalled. Throughput: one item per clock unless the buffer is full; each
// button has its own lane and the idle countdown is updated in the same cycle,
// so no loop limits the rate. Two output entries take one more item on a stall.
// Reset (synchronous, active high) releases all buttons, clears flags and
// counters, loads the idle countdown and restores the register defaults.
// ----------------------------------------------------------------------------
// button_debounce_long_press: three-button debouncer with long-press repeat
// Per-button lanes debounce and time presses; a merging stage builds the
// result and runs the idle timeout.
// ----------------------------------------------------------------------------
module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t                            cfg;
  lane_ctrl_t                      ctrl;
  lane_status_t [BUTTON_COUNT-1:0] status;
  logic                            buf_full;
  logic                            item_fire;

  assign item_stall = buf_full;
  assign item_fire  = item_valid && !item_stall;
  assign ctrl.tick  = item_fire && (item.action == ACTION_TICK);
  assign ctrl.ack   = item_fire && (item.action == ACTION_ACK);

  // Configuration registers.
  bdlp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // One lane per button.
  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    bdlp_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .raw       (item.raw_levels[i]),
      .clr_press (item.clear_press_mask[i]),
      .clr_long  (item.clear_long_mask[i]),
      .status    (status[i])
    );
  end

  // Merge lane reports and buffer the results.
  bdlp_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cfg          (cfg),
    .status       (status),
    .buf_full     (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* src/bdlp_checker.sv */
// ----------------------------------------------------------------------------
// bdlp_checker: port-level checks for the button debouncer
// Watches the item and result channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module bdlp_port_checker
  import bdlp_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or vanished");

  // Reset leaves the buffer empty and ready for a transfer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !item_stall && !result_valid)
    else $error("buffer not empty after reset");

  // Items are only held off while a result is waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item stalled with no result pending");

  // After every item transfer a result is offered in the next cycle.
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("no result after an item transfer");

endmodule

bind button_debounce_long_press bdlp_port_checker u_bdlp_port_checker (.*);

/* tb/bdlp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_checker: result predictor and scoreboard for the button debouncer
// Watches the register port and both payload channels, keeps its own copy of
// the debounce state, predicts one result per transferred item and compares
// every result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bdlp_checker
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    mismatch_count,
  output int                    pending_results
);

  // Shadow copy of the register file.
  logic        shadow_level;
  logic [15:0] shadow_long_ticks;
  logic [15:0] shadow_repeat_ticks;
  logic [15:0] shadow_idle_ticks;

  // Shadow copy of the per-button and shared state.
  logic [3:0]              history     [BUTTON_COUNT];
  logic [15:0]             hold_ticks  [BUTTON_COUNT];
  logic [15:0]             repeat_left [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] press_seen;
  logic [BUTTON_COUNT-1:0] long_seen;
  logic [15:0]             idle_left;

  result_t expected_results[$];
  int      result_index;

  // One line per failure, and the count goes up.
  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, result_index, msg);
    mismatch_count++;
  endtask

  // Applies one item to the shadow state and returns the result it causes.
  task automatic predict_debounced_result(input item_t it, output result_t r);
    logic s0, s1, s2, stable;
    logic stable_press;
    stable_press = 1'b0;
    if (it.action == ACTION_TICK) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        s0     = it.raw_levels[b];
        s1     = history[b][0];
        s2     = history[b][1];
        stable = history[b][3];
        if (s0 == s1 && s1 == s2) begin
          if (s2 != stable) begin
            // A new level has settled; a press edge arms the hold timer.
            stable = s2;
            if (stable == shadow_level) begin
              press_seen[b]  = 1'b1;
              hold_ticks[b]  = '0;
              repeat_left[b] = shadow_repeat_ticks;
              stable_press   = 1'b1;
            end
          end else if (s2 == shadow_level) begin
            // Held press: count up, then fire repeats once past the threshold.
            if (hold_ticks[b] != COUNT_MAX)
              hold_ticks[b] = hold_ticks[b] + 16'd1;
            if (hold_ticks[b] >= shadow_long_ticks) begin
              if (repeat_left[b] == 16'd0) begin
                long_seen[b]   = 1'b1;
                repeat_left[b] = shadow_repeat_ticks;
              end else begin
                repeat_left[b] = repeat_left[b] - 16'd1;
              end
            end
            stable_press = 1'b1;
          end
        end else begin
          // Bouncing input restarts the hold timing.
          hold_ticks[b]  = '0;
          repeat_left[b] = shadow_repeat_ticks;
        end
        history[b] = {stable, s2, s1, s0};
      end
      if (stable_press)
        idle_left = shadow_idle_ticks;
      else if (idle_left != 16'd0)
        idle_left = idle_left - 16'd1;
      r.press_flags = press_seen;
      r.long_flags  = long_seen;
    end else begin
      // Acknowledge reports the flags as they were, then clears by mask.
      r.press_flags = press_seen;
      r.long_flags  = long_seen;
      press_seen    = press_seen & ~it.clear_press_mask;
      long_seen     = long_seen & ~it.clear_long_mask;
    end
    r.any_raw_pressed = 1'b0;
    for (int b = 0; b < BUTTON_COUNT; b++)
      if (history[b][0] == shadow_level)
        r.any_raw_pressed = 1'b1;
    r.idle_expired = (idle_left == 16'd0);
  endtask

  // Results are checked before the item of the same edge is predicted, since
  // a result always belongs to an item transferred at an earlier edge.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      shadow_level        = PRESSED_LEVEL_RESET;
      shadow_long_ticks   = LONG_PRESS_TICKS_RESET;
      shadow_repeat_ticks = REPEAT_TICKS_RESET;
      shadow_idle_ticks   = IDLE_TIMEOUT_TICKS_RESET;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        history[b]     = HISTORY_RESET;
        hold_ticks[b]  = '0;
        repeat_left[b] = '0;
      end
      press_seen     = '0;
      long_seen      = '0;
      idle_left      = IDLE_TIMEOUT_TICKS_RESET;
      mismatch_count = 0;
      result_index   = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PRESSED_LEVEL:      shadow_level        = pwdata[0];
          REG_LONG_PRESS_TICKS:   shadow_long_ticks   = pwdata[15:0];
          REG_REPEAT_TICKS:       shadow_repeat_ticks = pwdata[15:0];
          REG_IDLE_TIMEOUT_TICKS: shadow_idle_ticks   = pwdata[15:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        got = result;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected: %h", got));
        end else begin
          want = expected_results.pop_front();
          if (got.press_flags !== want.press_flags)
            report_mismatch($sformatf("press_flags got %b expected %b",
                                      got.press_flags, want.press_flags));
          if (got.long_flags !== want.long_flags)
            report_mismatch($sformatf("long_flags got %b expected %b",
                                      got.long_flags, want.long_flags));
          if (got.any_raw_pressed !== want.any_raw_pressed)
            report_mismatch($sformatf("any_raw_pressed got %b expected %b",
                                      got.any_raw_pressed, want.any_raw_pressed));
          if (got.idle_expired !== want.idle_expired)
            report_mismatch($sformatf("idle_expired got %b expected %b",
                                      got.idle_expired, want.idle_expired));
        end
        result_index++;
      end
      if (item_valid && !item_stall) begin
        predict_debounced_result(item, want);
        expected_results.push_back(want);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

/* tb/tb_button_debounce_long_press.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press: regression for the button debouncer
// Drives directed press, hold, bounce, acknowledge and idle sequences, a held
// press into repeats at full rate, then random phases of mostly realistic
// button activity under several register settings, with random gaps and
// stalls on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press;
  import bdlp_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int HOLD_OFF_CYCLES  = 60;
  localparam int SATURATION_TICKS = 40;
  localparam int RANDOM_PHASES    = 5;
  localparam int PHASE_ITEMS      = 90;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;
  int gap_max     = 5;
  bit hold_off_req = 1'b0;

  button_debounce_long_press DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bdlp_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("button_debounce_long_press regression: fail");
      $finish;
    end
  end

  // Result receiver: a random hold-off before each transfer, and one long
  // hold-off on request so that the block backs up into its input.
  initial begin : result_receiver
    int unsigned wait_n;
    bit          hold_off_done;
    hold_off_done = 1'b0;
    result_stall  = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    @(negedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      wait_n = $urandom_range(0, gap_max);
      if (wait_n > 0) begin
        result_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!(result_valid && !result_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic item_t make_tick(input logic [BUTTON_COUNT-1:0] raw);
    item_t it;
    it.action           = ACTION_TICK;
    it.raw_levels       = raw;
    it.clear_press_mask = 3'($urandom_range(0, 7));
    it.clear_long_mask  = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic item_t make_ack(input logic [BUTTON_COUNT-1:0] press_mask,
                                     input logic [BUTTON_COUNT-1:0] long_mask);
    item_t it;
    it.action           = ACTION_ACK;
    it.raw_levels       = 3'($urandom_range(0, 7));
    it.clear_press_mask = press_mask;
    it.clear_long_mask  = long_mask;
    return it;
  endfunction

  // Mostly small counts so that events happen often, with the extremes mixed in.
  function automatic logic [15:0] pick_tick_count();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  // Offers one item after a random gap and returns once it is transferred.
  task automatic send_item(input item_t it);
    int unsigned wait_n;
    wait_n = $urandom_range(0, gap_max);
    if (wait_n > 0) begin
      item_valid <= 1'b0;
      repeat (wait_n) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain_results();
    item_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (3) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic apb_write(input logic [1:0] reg_index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_registers(input logic level, input logic [15:0] long_ticks,
                                   input logic [15:0] repeat_ticks,
                                   input logic [15:0] idle_ticks);
    apb_write(REG_PRESSED_LEVEL, {31'd0, level});
    apb_write(REG_LONG_PRESS_TICKS, {16'd0, long_ticks});
    apb_write(REG_REPEAT_TICKS, {16'd0, repeat_ticks});
    apb_write(REG_IDLE_TIMEOUT_TICKS, {16'd0, idle_ticks});
  endtask

  initial begin : stimulus
    logic [BUTTON_COUNT-1:0] target;
    logic [BUTTON_COUNT-1:0] raw;
    logic                    level;
    logic [1:0]              pick;
    int unsigned             roll;
    item_t                   it;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Short press, hold into repeats, acknowledge, bounce, release, idle out.
    program_registers(1'b0, 16'd2, 16'd1, 16'd3);
    send_item(make_tick(3'b111));
    repeat (3) send_item(make_tick(3'b000));
    repeat (5) send_item(make_tick(3'b000));
    send_item(make_ack(3'b111, 3'b111));
    send_item(make_tick(3'b101));
    send_item(make_tick(3'b010));
    repeat (3) send_item(make_tick(3'b111));
    repeat (4) send_item(make_tick(3'b111));

    // Level flipped with history kept; zero thresholds and zero idle timeout.
    drain_results();
    program_registers(1'b1, 16'd0, 16'd0, 16'd0);
    repeat (4) send_item(make_tick(3'b111));
    send_item(make_ack(3'b101, 3'b010));
    send_item(make_ack(3'b010, 3'b101));
    send_item(make_tick(3'b000));

    // Hold one long press into repeats, at full rate.
    drain_results();
    program_registers(1'b0, 16'd20, 16'd3, 16'hFFFF);
    gap_max = 0;
    repeat (SATURATION_TICKS) send_item(make_tick(3'b000));
    send_item(make_ack(3'b111, 3'b111));
    gap_max = 5;

    // Random phases: buttons follow held targets with occasional bounce,
    // mixed with acknowledges and raw noise.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      level = 1'($urandom_range(0, 1));
      program_registers(level, pick_tick_count(), pick_tick_count(), pick_tick_count());
      target  = {BUTTON_COUNT{~level}};
      gap_max = (phase == 2) ? 0 : 5;
      if (phase == 0)
        hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        for (int b = 0; b < BUTTON_COUNT; b++)
          if ($urandom_range(0, 11) == 0)
            target[b] = ~target[b];
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          it = make_ack(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        end else if (roll < 25) begin
          it = make_tick(3'($urandom_range(0, 7)));
        end else begin
          raw = target;
          if ($urandom_range(0, 9) == 0) begin
            pick      = 2'($urandom_range(0, BUTTON_COUNT - 1));
            raw[pick] = ~raw[pick];
          end
          it = make_tick(raw);
        end
        send_item(it);
      end
    end

    // Let the last results come out, then give the verdict.
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("button_debounce_long_press regression: pass");
    end else begin
      $display("button_debounce_long_press regression: fail");
    end
    $finish;
  end

endmodule
